FILE: sv/tmse_pkg.sv
// ----------------------------------------------------------------------------
// Turing machine step engine package
// Sizes, command and status codes, and the rule entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package tmse_pkg;

	localparam int TAPE_CELLS = 1024;
	localparam int RULE_SLOTS = 64;

	localparam int ADDR_W = $clog2(TAPE_CELLS);
	localparam int RIDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
	localparam int CNT_W  = $clog2(RULE_SLOTS + 1);
	localparam int LIM_W  = (CNT_W > 7) ? CNT_W : 7;

	localparam logic [2:0] OP_LOAD    = 3'd0;
	localparam logic [2:0] OP_WRITE   = 3'd1;
	localparam logic [2:0] OP_READ    = 3'd2;
	localparam logic [2:0] OP_RESTART = 3'd3;
	localparam logic [2:0] OP_STEP    = 3'd4;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_HALTED  = 3'd1;
	localparam logic [2:0] ST_NO_RULE = 3'd2;
	localparam logic [2:0] ST_LEFT    = 3'd3;
	localparam logic [2:0] ST_RIGHT   = 3'd4;
	localparam logic [2:0] ST_STOPPED = 3'd5;

	localparam logic [1:0] MV_LEFT  = 2'd0;
	localparam logic [1:0] MV_STAY  = 2'd1;
	localparam logic [1:0] MV_RIGHT = 2'd2;
	localparam logic [1:0] MV_HALT  = 2'd3;

	typedef struct packed {
		logic [7:0] match_state;
		logic [7:0] match_symbol;
		logic [7:0] write_symbol;
		logic [1:0] move;
		logic [7:0] next_state;
	} rule_t;

endpackage

`default_nettype wire

FILE: sv/tmse_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tmse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                         clk,
	input  wire logic                                         we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                             wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: sv/turing_machine_step_engine.sv
// ----------------------------------------------------------------------------
// Turing machine step engine
// Single-tape machine with a loadable rule table and a tape memory.
// ----------------------------------------------------------------------------
// After reset the engine clears the tape, one cell per cycle, and accepts no
// request until all TAPE_CELLS (1024) cells are cleared. Rule loads, tape
// writes, restarts and requests that do nothing pass through S_EXEC to S_RESP;
// a tape read goes through S_EXEC, S_RDWAIT and S_RESP. A step reads the head
// symbol in S_SYM, then scans the rule table one slot per cycle through the
// rule memory's read port in S_SEARCH, up to the first match or at most
// min(rule_count, RULE_SLOTS) slots. A result waits in an output register until
// it is taken.
`default_nettype none

module turing_machine_step_engine
	import tmse_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [6:0] cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [2:0] opcode,
	input  wire logic [9:0] cell_address,
	input  wire logic [7:0] cell_symbol,
	input  wire logic [5:0] rule_index,
	input  wire logic [7:0] rule_match_state,
	input  wire logic [7:0] rule_match_symbol,
	input  wire logic [7:0] rule_write_symbol,
	input  wire logic [1:0] rule_move,
	input  wire logic [7:0] rule_next_state,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [2:0]      status,
	output logic [7:0]      current_state_out,
	output logic [9:0]      head_out,
	output logic [7:0]      read_symbol,
	output logic            running
);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_EXEC   = 3'd2;
	localparam logic [2:0] S_RDWAIT = 3'd3;
	localparam logic [2:0] S_SYM    = 3'd4;
	localparam logic [2:0] S_SEARCH = 3'd5;
	localparam logic [2:0] S_RESP   = 3'd6;

	logic [2:0]        state_q;
	logic [ADDR_W-1:0] clr_idx_q;
	logic [ADDR_W-1:0] head_q;
	logic [7:0]        mstate_q;
	logic              run_q;
	logic [6:0]        rule_count_q;
	logic [RIDX_W-1:0] rd_idx_q;
	logic [RIDX_W-1:0] cmp_idx_q;
	logic              out_valid_q;

	logic [2:0]        op_q;
	logic [9:0]        addr_q;
	logic [7:0]        csym_q;
	logic [5:0]        ridx_q;
	rule_t             rule_in_q;
	logic [7:0]        sym_q;
	logic [2:0]        status_q;
	logic [7:0]        rdsym_q;
	logic [2:0]        out_status_q;
	logic [7:0]        out_state_q;
	logic [9:0]        out_head_q;
	logic [7:0]        out_rdsym_q;
	logic              out_run_q;

	logic              accept;
	logic              addr_ok;
	logic              idx_ok;
	logic [LIM_W-1:0]  limit;
	logic              last_rule;
	logic              hit;
	logic              head_at_end;
	logic              resp_load;
	logic [2:0]        step_status;

	logic              tape_we;
	logic [ADDR_W-1:0] tape_waddr;
	logic [7:0]        tape_wdata;
	logic [ADDR_W-1:0] tape_raddr;
	logic [7:0]        tape_rdata;
	logic              rule_we;
	rule_t             rule_rd;

	assign in_ready    = (state_q == S_IDLE);
	assign accept      = in_valid && in_ready;
	assign addr_ok     = 32'(addr_q) < 32'(TAPE_CELLS);
	assign idx_ok      = 32'(ridx_q) < 32'(RULE_SLOTS);
	assign limit       = (LIM_W'(rule_count_q) > LIM_W'(RULE_SLOTS)) ?
	                     LIM_W'(RULE_SLOTS) : LIM_W'(rule_count_q);
	assign last_rule   = (LIM_W'(cmp_idx_q) + LIM_W'(1)) == limit;
	assign hit         = (state_q == S_SEARCH) && (rule_rd.match_state == mstate_q)
	                     && (rule_rd.match_symbol == sym_q);
	assign head_at_end = head_q == ADDR_W'(TAPE_CELLS - 1);
	assign resp_load   = (state_q == S_RESP) && (!out_valid_q || out_ready);

	always_comb begin
		case (rule_rd.move)
			MV_LEFT:  step_status = (head_q == '0) ? ST_LEFT : ST_OK;
			MV_STAY:  step_status = ST_OK;
			MV_RIGHT: step_status = head_at_end ? ST_RIGHT : ST_OK;
			default:  step_status = ST_HALTED;
		endcase
	end

	always_comb begin
		tape_we    = 1'b0;
		tape_waddr = head_q;
		tape_wdata = rule_rd.write_symbol;
		case (state_q)
			S_CLEAR: begin
				tape_we    = 1'b1;
				tape_waddr = clr_idx_q;
				tape_wdata = '0;
			end
			S_EXEC: begin
				if (op_q == OP_WRITE && addr_ok) begin
					tape_we    = 1'b1;
					tape_waddr = ADDR_W'(addr_q);
					tape_wdata = csym_q;
				end
			end
			S_SEARCH: begin
				tape_we = hit;
			end
			default: begin
			end
		endcase
	end

	assign tape_raddr = (op_q == OP_READ) ? ADDR_W'(addr_q) : head_q;
	assign rule_we    = (state_q == S_EXEC) && (op_q == OP_LOAD) && idx_ok;

	tmse_ram #(
		.WIDTH (8),
		.DEPTH (TAPE_CELLS)
	) u_tape (
		.clk   (clk),
		.we    (tape_we),
		.waddr (tape_waddr),
		.wdata (tape_wdata),
		.raddr (tape_raddr),
		.rdata (tape_rdata)
	);

	tmse_ram #(
		.WIDTH ($bits(rule_t)),
		.DEPTH (RULE_SLOTS)
	) u_rules (
		.clk   (clk),
		.we    (rule_we),
		.waddr (RIDX_W'(ridx_q)),
		.wdata (rule_in_q),
		.raddr (rd_idx_q),
		.rdata (rule_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_idx_q    <= '0;
			head_q       <= ADDR_W'(1);
			mstate_q     <= '0;
			run_q        <= 1'b1;
			rule_count_q <= '0;
			rd_idx_q     <= '0;
			cmp_idx_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				rule_count_q <= cfg_wdata;
			end
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + ADDR_W'(1);
					if (clr_idx_q == ADDR_W'(TAPE_CELLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_RESP;
					case (op_q)
						OP_READ: begin
							state_q <= S_RDWAIT;
						end
						OP_RESTART: begin
							mstate_q <= '0;
							head_q   <= ADDR_W'(1);
							run_q    <= 1'b1;
						end
						OP_STEP: begin
							if (run_q && limit == '0) begin
								run_q <= 1'b0;
							end else if (run_q) begin
								rd_idx_q <= '0;
								state_q  <= S_SYM;
							end
						end
						default: begin
						end
					endcase
				end
				S_RDWAIT: begin
					state_q <= S_RESP;
				end
				S_SYM: begin
					rd_idx_q  <= rd_idx_q + RIDX_W'(1);
					cmp_idx_q <= rd_idx_q;
					state_q   <= S_SEARCH;
				end
				S_SEARCH: begin
					rd_idx_q  <= rd_idx_q + RIDX_W'(1);
					cmp_idx_q <= cmp_idx_q + RIDX_W'(1);
					if (hit) begin
						mstate_q <= rule_rd.next_state;
						state_q  <= S_RESP;
						case (rule_rd.move)
							MV_LEFT: begin
								if (head_q == '0) begin
									run_q <= 1'b0;
								end else begin
									head_q <= head_q - ADDR_W'(1);
								end
							end
							MV_STAY: begin
							end
							MV_RIGHT: begin
								if (head_at_end) begin
									run_q <= 1'b0;
								end else begin
									head_q <= head_q + ADDR_W'(1);
								end
							end
							default: begin
								run_q <= 1'b0;
							end
						endcase
					end else if (last_rule) begin
						run_q   <= 1'b0;
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (resp_load) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q                   <= opcode;
			addr_q                 <= cell_address;
			csym_q                 <= cell_symbol;
			ridx_q                 <= rule_index;
			rule_in_q.match_state  <= rule_match_state;
			rule_in_q.match_symbol <= rule_match_symbol;
			rule_in_q.write_symbol <= rule_write_symbol;
			rule_in_q.move         <= rule_move;
			rule_in_q.next_state   <= rule_next_state;
		end
		case (state_q)
			S_EXEC: begin
				status_q <= ST_OK;
				rdsym_q  <= '0;
				if (op_q == OP_STEP) begin
					if (!run_q) begin
						status_q <= ST_STOPPED;
					end else if (limit == '0) begin
						status_q <= ST_NO_RULE;
					end
				end
			end
			S_RDWAIT: begin
				rdsym_q <= addr_ok ? tape_rdata : '0;
			end
			S_SYM: begin
				sym_q <= tape_rdata;
			end
			S_SEARCH: begin
				if (hit) begin
					status_q <= step_status;
				end else if (last_rule) begin
					status_q <= ST_NO_RULE;
				end
			end
			default: begin
			end
		endcase
		if (resp_load) begin
			out_status_q <= status_q;
			out_state_q  <= mstate_q;
			out_head_q   <= 10'(head_q);
			out_rdsym_q  <= rdsym_q;
			out_run_q    <= run_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign status            = out_status_q;
	assign current_state_out = out_state_q;
	assign head_out          = out_head_q;
	assign read_symbol       = out_rdsym_q;
	assign running           = out_run_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("engine still ready after taking a request");

	a_stop_clears_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_HALTED || status == ST_NO_RULE || status == ST_LEFT
		|| status == ST_RIGHT || status == ST_STOPPED) |-> !running)
		else $error("stopping status reported while still running");

	a_head_in_tape: assert property (@(posedge clk) disable iff (!arst_n)
		32'(head_q) < 32'(TAPE_CELLS))
		else $error("head outside the tape");

	a_no_write_while_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_RESP) |-> !tape_we && !rule_we)
		else $error("memory written outside the command sequence");

endmodule

`default_nettype wire
